[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL; empty when synthesizing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked on every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

[rtl/gmap_pkg.sv]
package gmap_pkg;

    localparam int DEFAULT_WINDOW_DEPTH = 64;
    localparam int DEFAULT_SAMPLE_BITS  = 32;

    // width of the window length field as written on the config port
    localparam int CFG_LEN_WIDTH = 7;
    localparam int CFG_INDEX_WIDTH = 2;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_LOWER_BOUND   = 2'd0,
        REG_UPPER_BOUND   = 2'd1,
        REG_WINDOW_LENGTH = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_START,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

[rtl/gmap_divider.sv]
`include "assert_macros.svh"

module gmap_divider #(
    parameter int SUM_BITS = gmap_pkg::DEFAULT_SAMPLE_BITS + 6,
    parameter int LEN_BITS = 7
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [SUM_BITS-1:0]  dividend,
    input  logic        [LEN_BITS-1:0]  divisor,
    output gmap_pkg::div_stat_t         stat,
    output logic signed [SUM_BITS-1:0]  quotient
);
    import gmap_pkg::*;

    localparam int CNT_BITS = $clog2(SUM_BITS + 1);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                neg_reg;
    logic [SUM_BITS-1:0] shift_reg;
    logic [SUM_BITS-1:0] shift_next;
    logic [LEN_BITS-1:0] rem_reg;
    logic [LEN_BITS-1:0] rem_next;
    logic [LEN_BITS:0]   trial;
    logic [LEN_BITS:0]   trial_diff;
    logic                fits;
    logic [SUM_BITS-1:0] dividend_mag;

    assign dividend_mag = dividend[SUM_BITS-1] ? SUM_BITS'(-dividend) : SUM_BITS'(dividend);

    // one restoring step: bring down the next dividend bit, subtract if it fits
    always_comb
    begin
        trial      = {rem_reg, shift_reg[SUM_BITS-1]};
        trial_diff = trial - (LEN_BITS + 1)'(divisor);
        fits       = (trial >= (LEN_BITS + 1)'(divisor));
        rem_next   = fits ? trial_diff[LEN_BITS-1:0] : trial[LEN_BITS-1:0];
        shift_next = {shift_reg[SUM_BITS-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(SUM_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= dividend_mag;
            rem_reg   <= '0;
            neg_reg   <= dividend[SUM_BITS-1];
        end
        else if (busy_reg)
        begin
            shift_reg <= shift_next;
            rem_reg   <= rem_next;
        end
    end

    // truncate toward zero: divide magnitudes, then restore the sign
    assign quotient  = neg_reg ? -$signed(shift_reg) : $signed(shift_reg);
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    `ASSERT_NEVER(a_start_while_busy, clk, rst_n, start && busy_reg, "divider restarted while busy")
    `ASSERT_CLK(a_busy_count, clk, rst_n, busy_reg |-> (cnt_reg != '0), "busy with no steps left")
    `ASSERT_CLK(a_done_after_busy, clk, rst_n, done_reg |-> ($past(busy_reg) && !busy_reg), "done without a finished run")

endmodule

[rtl/gated_moving_average_peaks_unit.sv]
// Gated moving average with peak tracking. Each transfer on the input channel
// carries one signed fixed-point sample; a sample outside [lower_bound,
// upper_bound] is dropped and the result repeats the last accepted sample with
// accepted low. An accepted sample replaces the oldest entry of a circular
// window of window_length entries (entries still zero from reset or from a
// length write count), and the result is the window sum divided by the length,
// truncated toward zero, together with the running maximum of accepted samples
// below upper_bound and minimum of those above lower_bound. Accepted samples
// go through the bit-per-cycle divider; dropped samples skip it. One item is
// in flight at a time, and the next input is taken while the previous result
// waits in the output register. Writing window_length clears the window at
// once; writing lower_bound restarts the maximum tracker and upper_bound the
// minimum one. Write configuration only when idle.
`include "assert_macros.svh"

module gated_moving_average_peaks_unit #(
    parameter int WINDOW_DEPTH = gmap_pkg::DEFAULT_WINDOW_DEPTH,
    parameter int SAMPLE_BITS  = gmap_pkg::DEFAULT_SAMPLE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  gmap_pkg::cfg_reg_t            cfg_index,
    input  logic        [SAMPLE_BITS-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] average_out,
    output logic                          accepted,
    output logic signed [SAMPLE_BITS-1:0] peak_max,
    output logic signed [SAMPLE_BITS-1:0] peak_min
);
    import gmap_pkg::*;

    localparam int SLOT_BITS  = $clog2(WINDOW_DEPTH);
    localparam int LEN_BITS   = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_BITS   = SAMPLE_BITS + SLOT_BITS;
    localparam int CLAMP_BITS = (LEN_BITS > CFG_LEN_WIDTH) ? LEN_BITS : CFG_LEN_WIDTH;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    state_t state_reg;
    state_t state_next;

    // configuration
    logic signed [SAMPLE_BITS-1:0] lower_reg;
    logic signed [SAMPLE_BITS-1:0] upper_reg;
    logic        [LEN_BITS-1:0]    len_reg;
    logic        [LEN_BITS-1:0]    len_next;
    logic [CFG_LEN_WIDTH-1:0]      len_raw;
    logic [CLAMP_BITS-1:0]         len_wide;

    // window state
    logic signed [SAMPLE_BITS-1:0] win_mem [WINDOW_DEPTH];
    logic                          wrapped_reg;
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;
    logic                          rd_valid_reg;
    logic        [SLOT_BITS-1:0]   write_slot_reg;
    logic        [SLOT_BITS-1:0]   write_slot_next;
    logic        [LEN_BITS-1:0]    slot_inc;
    logic signed [SUM_BITS-1:0]    sum_reg;
    logic signed [SUM_BITS-1:0]    sum_next;
    logic signed [SAMPLE_BITS-1:0] old_val;
    logic signed [SAMPLE_BITS-1:0] last_reg;
    logic signed [SAMPLE_BITS-1:0] max_reg;
    logic signed [SAMPLE_BITS-1:0] min_reg;

    // item in flight
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                          gate_reg;
    logic                          in_range;

    // output register
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] average_reg;
    logic                          accepted_reg;
    logic signed [SAMPLE_BITS-1:0] peak_max_reg;
    logic signed [SAMPLE_BITS-1:0] peak_min_reg;

    // sequencer strobes
    logic load_item;
    logic update;
    logic div_start;
    logic load_out;

    div_stat_t                  div_stat;
    logic signed [SUM_BITS-1:0] div_quot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        load_item  = 1'b0;
        update     = 1'b0;
        div_start  = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    load_item  = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (gate_reg)
                begin
                    update     = 1'b1;
                    state_next = ST_START;
                end
                else
                    state_next = ST_DONE;
            end
            ST_START:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // clamp the written length into 1..WINDOW_DEPTH
    always_comb
    begin
        len_raw  = cfg_data[CFG_LEN_WIDTH-1:0];
        len_wide = CLAMP_BITS'(len_raw);
        if (len_raw == '0)
            len_next = LEN_BITS'(1);
        else if (len_wide > CLAMP_BITS'(WINDOW_DEPTH))
            len_next = LEN_BITS'(WINDOW_DEPTH);
        else
            len_next = len_wide[LEN_BITS-1:0];
    end

    assign in_range = (sample >= lower_reg) && (sample <= upper_reg);

    // read-modify-write of the oldest entry; an entry never written reads as zero
    always_comb
    begin
        old_val  = rd_valid_reg ? rd_data_reg : '0;
        sum_next = sum_reg - {{SLOT_BITS{old_val[SAMPLE_BITS-1]}}, old_val}
                           + {{SLOT_BITS{sample_reg[SAMPLE_BITS-1]}}, sample_reg};
        slot_inc = LEN_BITS'(write_slot_reg) + LEN_BITS'(1);
        write_slot_next = (slot_inc == len_reg) ? '0 : slot_inc[SLOT_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (load_item)
            rd_data_reg <= win_mem[write_slot_reg];
        if (update)
            win_mem[write_slot_reg] <= sample_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load_item)
        begin
            sample_reg   <= sample;
            gate_reg     <= in_range;
            rd_valid_reg <= wrapped_reg;
        end
    end

    // slots fill in order from zero, so all of them hold data once the slot wraps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wrapped_reg <= 1'b0;
        else if (cfg_we && cfg_index == REG_WINDOW_LENGTH)
            wrapped_reg <= 1'b0;
        else if (update && slot_inc == len_reg)
            wrapped_reg <= 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg      <= SAMPLE_MIN;
            upper_reg      <= SAMPLE_MAX;
            len_reg        <= LEN_BITS'(WINDOW_DEPTH);
            max_reg        <= SAMPLE_MIN;
            min_reg        <= SAMPLE_MAX;
            sum_reg        <= '0;
            write_slot_reg <= '0;
            last_reg       <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LOWER_BOUND:
                begin
                    lower_reg <= cfg_data;
                    max_reg   <= cfg_data;
                end
                REG_UPPER_BOUND:
                begin
                    upper_reg <= cfg_data;
                    min_reg   <= cfg_data;
                end
                REG_WINDOW_LENGTH:
                begin
                    len_reg        <= len_next;
                    sum_reg        <= '0;
                    write_slot_reg <= '0;
                end
                default:
                begin
                    // unknown index: ignore the write
                end
            endcase
        end
        else if (update)
        begin
            sum_reg        <= sum_next;
            write_slot_reg <= write_slot_next;
            last_reg       <= sample_reg;
            if (sample_reg > max_reg && sample_reg < upper_reg)
                max_reg <= sample_reg;
            if (sample_reg < min_reg && sample_reg > lower_reg)
                min_reg <= sample_reg;
        end
    end

    gmap_divider #(
        .SUM_BITS (SUM_BITS),
        .LEN_BITS (LEN_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (len_reg),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            // dropped sample: repeat the last accepted one
            average_reg  <= gate_reg ? div_quot[SAMPLE_BITS-1:0] : last_reg;
            accepted_reg <= gate_reg;
            peak_max_reg <= max_reg;
            peak_min_reg <= min_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign average_out = average_reg;
    assign accepted    = accepted_reg;
    assign peak_max    = peak_max_reg;
    assign peak_min    = peak_min_reg;

    `ASSERT_CLK(a_slot_in_window, clk, rst_n, LEN_BITS'(write_slot_reg) < len_reg, "write slot beyond window length")
    `ASSERT_CLK(a_one_item, clk, rst_n, (in_valid && !in_stall) |=> (state_reg == ST_READ), "input taken while an item is in flight")
    `ASSERT_CLK(a_drop_skips_div, clk, rst_n, (state_reg == ST_DIV) |-> gate_reg, "dropped sample reached the divider")
    `ASSERT_NEVER(a_div_overlap, clk, rst_n, div_start && div_stat.busy, "divider started while busy")

endmodule
